// File: rtl/cfpr_pkg.sv
package cfpr_pkg;

  localparam int unsigned MaxPayloadBytes = 32;
  localparam int unsigned MinFrame        = 5;   // head, type, crc lo, crc hi, tail
  localparam int unsigned PayloadBase     = 2;   // first payload byte sits after head and type
  localparam int unsigned PcntW           = 6;   // payload_count width

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] HeadReset = 8'hC5;
  localparam logic [7:0] TailReset = 8'h5C;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgHead = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTail = 1'b1;

endpackage

// File: rtl/cfpr_ifs.sv
interface cfpr_cfg_if;
  import cfpr_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [7:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface cfpr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink   (input valid, rx_byte, output ready);
endinterface

interface cfpr_result_if;
  import cfpr_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       frame_type;
  logic [7:0]       payload_byte;
  logic             has_byte;
  logic [PcntW-1:0] payload_count;
  logic             last;

  modport source (output valid, frame_type, payload_byte, has_byte, payload_count, last,
                  input ready);
  modport sink   (input valid, frame_type, payload_byte, has_byte, payload_count, last,
                  output ready);
endinterface

// File: rtl/crc16_framed_packet_receiver.sv
// Head/tail framed packet receiver with CRC-16/MODBUS check. One received byte is
// taken per transfer on rx_i. Bytes that are not folded into the CRC (waiting for head,
// the first three bytes of a frame, an overflow drop) are handled within their transfer
// cycle. Every later byte also passes through 8 steps of the single shift/xor CRC unit,
// which handles one bit per cycle. A tail byte that is folded then leads to a check step.
// A valid frame is then replayed on res_o, each result taking a frame store read, then
// an output register load, plus any stall from the sink; an empty payload gives a single
// result without a store read. rx_i is not ready during folding, check and replay, but the
// final result may still wait in the output register while new bytes are taken. The frame
// store needs no clearing pass after reset. Configuration writes are taken every cycle.
module crc16_framed_packet_receiver #(
  parameter int unsigned MAX_PAYLOAD_BYTES = cfpr_pkg::MaxPayloadBytes
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cfpr_cfg_if.sink              cfg_i,
  cfpr_byte_if.sink             rx_i,
  cfpr_result_if.source         res_o
);
  import cfpr_pkg::*;

  localparam int unsigned FrameCap = MAX_PAYLOAD_BYTES + MinFrame;
  localparam int unsigned AddrW    = $clog2(FrameCap);
  localparam int unsigned CntW     = $clog2(FrameCap + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FOLD  = 5'b00010,
    S_CHECK = 5'b00100,
    S_READ  = 5'b01000,
    S_LOAD  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       head_cfg_q, tail_cfg_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [15:0]      crc_q, crc_d;
  logic [2:0]       bit_cnt_q, bit_cnt_d;
  logic             tail_hit_q, tail_hit_d;
  logic [7:0]       head_q, head_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       taps_q [3];
  logic [7:0]       taps_d [3];
  logic [PcntW-1:0] plen_q, plen_d;
  logic [PcntW-1:0] rd_idx_q, rd_idx_d;
  logic             empty_q, empty_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_type_q, out_type_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_has_q, out_has_d;
  logic [PcntW-1:0] out_cnt_q, out_cnt_d;
  logic             out_last_q, out_last_d;

  logic [7:0]       mem_q [FrameCap];
  logic [7:0]       rdata_q;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [PcntW:0]   rd_sum;

  logic             rx_fire, cfg_fire, load_last;
  logic [15:0]      crc_shr, crc_step;

  assign rx_i.ready  = (state_q == S_IDLE);
  assign rx_fire     = rx_i.valid && rx_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  // one bit of the reflected CRC per cycle
  assign crc_shr  = {1'b0, crc_q[15:1]};
  assign crc_step = crc_q[0] ? (crc_shr ^ CrcPoly) : crc_shr;

  assign wr_addr   = count_q[AddrW-1:0];
  assign rd_sum    = {1'b0, rd_idx_q} + (PcntW + 1)'(PayloadBase);
  assign rd_addr   = AddrW'(rd_sum);
  assign load_last = empty_q || (PcntW'(rd_idx_q + 1'b1) == plen_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    len_d       = len_q;
    crc_d       = crc_q;
    bit_cnt_d   = bit_cnt_q;
    tail_hit_d  = tail_hit_q;
    head_d      = head_q;
    type_d      = type_q;
    taps_d      = taps_q;
    plen_d      = plen_q;
    rd_idx_d    = rd_idx_q;
    empty_d     = empty_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;
    out_type_d  = out_type_q;
    out_byte_d  = out_byte_q;
    out_has_d   = out_has_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (rx_fire) begin
          if (count_q == '0) begin
            if (rx_i.rx_byte == head_cfg_q) begin
              head_d    = rx_i.rx_byte;
              // head starts the tap line; it is the first byte folded
              taps_d[0] = rx_i.rx_byte;
              count_d   = CntW'(1);
              crc_d     = CrcInit;
            end
          end else if (count_q >= CntW'(FrameCap)) begin
            // overflow: drop this byte and the frame
            count_d = '0;
          end else begin
            wr_en      = 1'b1;
            taps_d[0]  = rx_i.rx_byte;
            taps_d[1]  = taps_q[0];
            taps_d[2]  = taps_q[1];
            if (count_q == CntW'(1)) begin
              type_d = rx_i.rx_byte;
            end
            count_d    = count_q + 1'b1;
            tail_hit_d = (rx_i.rx_byte == tail_cfg_q);
            if (rx_i.rx_byte == tail_cfg_q) begin
              count_d = '0;
              len_d   = count_q + 1'b1;
            end
            // byte three places back joins the CRC; a tail before that is a short frame
            if (count_q >= CntW'(3)) begin
              crc_d     = crc_q ^ {8'h00, taps_q[2]};
              bit_cnt_d = '0;
              state_d   = S_FOLD;
            end
          end
        end
      end
      S_FOLD: begin
        crc_d     = crc_step;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == 3'd7) begin
          state_d = tail_hit_q ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        // received CRC is little-endian: low byte two back from the tail
        if (len_q >= CntW'(MinFrame) && head_q == head_cfg_q &&
            crc_q == {taps_q[1], taps_q[2]}) begin
          plen_d   = PcntW'(len_q - CntW'(MinFrame));
          rd_idx_d = '0;
          empty_d  = (len_q == CntW'(MinFrame));
          state_d  = (len_q == CntW'(MinFrame)) ? S_LOAD : S_READ;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_type_d  = type_q;
          out_byte_d  = empty_q ? 8'h00 : rdata_q;
          out_has_d   = !empty_q;
          out_cnt_d   = plen_q;
          out_last_d  = load_last;
          rd_idx_d    = rd_idx_q + 1'b1;
          state_d     = load_last ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      head_cfg_q  <= HeadReset;
      tail_cfg_q  <= TailReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        unique case (cfg_i.index)
          CfgHead: head_cfg_q <= cfg_i.data;
          CfgTail: tail_cfg_q <= cfg_i.data;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    crc_q      <= crc_d;
    tail_hit_q <= tail_hit_d;
    head_q     <= head_d;
    type_q     <= type_d;
    taps_q     <= taps_d;
    plen_q     <= plen_d;
    rd_idx_q   <= rd_idx_d;
    empty_q    <= empty_d;
    out_type_q <= out_type_d;
    out_byte_q <= out_byte_d;
    out_has_q  <= out_has_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= rx_i.rx_byte;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.frame_type    = out_type_q;
  assign res_o.payload_byte  = out_byte_q;
  assign res_o.has_byte      = out_has_q;
  assign res_o.payload_count = out_cnt_q;
  assign res_o.last          = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FrameCap))
    else $error("byte count beyond frame capacity");

  a_bit_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FOLD) |-> (bit_cnt_q == 3'd0) || $past(state_q == S_FOLD))
    else $error("CRC bit counter left running outside fold");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.has_byte) |-> (res_o.last && res_o.payload_count == '0))
    else $error("empty-payload result not marked last with zero count");

  a_fold_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOLD && bit_cnt_q == 3'd7 && tail_hit_q) |=> (state_q == S_CHECK))
    else $error("tail byte fold did not lead to frame check");

endmodule

// File: sim/tb_crc16_framed_packet_receiver.sv
`timescale 1ns / 1ps

module tb_crc16_framed_packet_receiver;
  import cfpr_pkg::*;

  localparam int unsigned FrameCap = MaxPayloadBytes + MinFrame;
  localparam int unsigned SettleCycles = 40;  // CRC unit, check cycle and replay tail

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0]       frame_type;
    logic [7:0]       payload_byte;
    logic             has_byte;
    logic [PcntW-1:0] payload_count;
    logic             last;
  } frame_result_t;

  logic clk;
  logic rst_n;

  cfpr_cfg_if    cfg ();
  cfpr_byte_if   rxb ();
  cfpr_result_if res ();

  crc16_framed_packet_receiver dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg),
    .rx_i   (rxb),
    .res_o  (res)
  );

  // Receiver-side copy of the frame state
  logic [7:0]    head_val;
  logic [7:0]    tail_val;
  logic [7:0]    frame_buf [FrameCap];
  int unsigned   rx_len;
  frame_result_t replay_q[$];

  int unsigned mismatches;
  int unsigned items_taken;
  bit          idle_en;
  int unsigned rx_gap_pct;
  int unsigned res_stall_pct;
  int unsigned stall_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the frame state by one accepted byte, queueing any replayed results
  function automatic void frame_rx_step(input logic [7:0] b);
    int unsigned   len;
    int unsigned   plen;
    logic [15:0]   crc;
    frame_result_t r;
    if (rx_len != 0 || b == head_val) items_taken++;
    if (rx_len == 0) begin
      if (b == head_val) begin
        frame_buf[0] = b;
        rx_len = 1;
      end
      return;
    end
    if (rx_len >= FrameCap) begin
      // store full: byte dropped, frame abandoned
      rx_len = 0;
      return;
    end
    frame_buf[rx_len] = b;
    rx_len++;
    if (b != tail_val) return;
    len = rx_len;
    rx_len = 0;
    if (len < MinFrame || frame_buf[0] != head_val) return;
    crc = CrcInit;
    for (int unsigned i = 0; i < len - 3; i++) crc = crc_fold(crc, frame_buf[i]);
    if (crc != {frame_buf[len-2], frame_buf[len-3]}) return;
    plen = len - MinFrame;
    r.frame_type = frame_buf[1];
    if (plen == 0) begin
      r.payload_byte  = 8'h00;
      r.has_byte      = 1'b0;
      r.payload_count = '0;
      r.last          = 1'b1;
      replay_q.push_back(r);
      return;
    end
    for (int unsigned i = 0; i < plen; i++) begin
      r.payload_byte  = frame_buf[PayloadBase + i];
      r.has_byte      = 1'b1;
      r.payload_count = PcntW'(plen);
      r.last          = (i + 1 == plen);
      replay_q.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result sink: random stall bursts while idling is enabled
  always @(posedge clk) begin
    if (stall_left != 0) begin
      res.ready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 99) < res_stall_pct) begin
      res.ready <= 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && res.valid && res.ready) begin
      if (replay_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual type 0x%0h byte 0x%0h last %0b",
                 $time, res.frame_type, res.payload_byte, res.last);
        mismatches++;
      end else begin
        want = replay_q.pop_front();
        check_field("frame_type", want.frame_type, res.frame_type);
        check_field("payload_byte", want.payload_byte, res.payload_byte);
        check_field("has_byte", 8'(want.has_byte), 8'(res.has_byte));
        check_field("payload_count", 8'(want.payload_count), 8'(res.payload_count));
        check_field("last", 8'(want.last), 8'(res.last));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 99) < rx_gap_pct) begin
      rxb.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    rxb.valid   <= 1'b1;
    rxb.rx_byte <= b;
    do @(posedge clk); while (!rxb.ready);
    frame_rx_step(b);
  endtask

  // Both markers are written back to back; valid stays up between the two transfers
  task automatic set_markers(input logic [7:0] h, input logic [7:0] t);
    cfg.valid <= 1'b1;
    cfg.index <= CfgHead;
    cfg.data  <= h;
    do @(posedge clk); while (!cfg.ready);
    head_val = h;
    cfg.index <= CfgTail;
    cfg.data  <= t;
    do @(posedge clk); while (!cfg.ready);
    tail_val = t;
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    rxb.valid <= 1'b0;
    while (replay_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_packet(input logic [7:0] ftype, input byte_q_t pl,
                             input logic [15:0] crc_flip);
    byte_q_t     bytes;
    logic [15:0] crc;
    bytes.push_back(head_val);
    bytes.push_back(ftype);
    foreach (pl[i]) bytes.push_back(pl[i]);
    crc = CrcInit;
    foreach (bytes[i]) crc = crc_fold(crc, bytes[i]);
    crc ^= crc_flip;
    bytes.push_back(crc[7:0]);
    bytes.push_back(crc[15:8]);
    bytes.push_back(tail_val);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Mostly steers clear of the tail so frames run to their intended length
  function automatic logic [7:0] rand_body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == tail_val && $urandom_range(0, 19) != 0) b ^= 8'h80;
    return b;
  endfunction

  function automatic byte_q_t rand_payload(input int unsigned n);
    byte_q_t pl;
    repeat (n) pl.push_back(rand_body_byte());
    return pl;
  endfunction

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned plen;
    logic [7:0]  ftype;
    logic [7:0]  b;
    kind  = $urandom_range(0, 99);
    ftype = rand_body_byte();
    plen  = (kind < 10) ? $urandom_range(9, MaxPayloadBytes) : $urandom_range(0, 8);
    if (kind >= 90) begin
      // line noise between frames, rarely a stray head
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == head_val && $urandom_range(0, 3) != 0) b ^= 8'h01;
        send_byte(b);
      end
    end else if (kind >= 85) begin
      send_byte(head_val);
      repeat ($urandom_range(0, 2)) send_byte(rand_body_byte());
      send_byte(tail_val);
    end else if (kind >= 80) begin
      send_packet(ftype, rand_payload(MaxPayloadBytes + $urandom_range(1, 2)), 16'h0000);
    end else if (kind >= 70) begin
      send_packet(ftype, rand_payload(plen), 16'(1 << $urandom_range(0, 15)));
    end else begin
      send_packet(ftype, rand_payload(plen), 16'h0000);
    end
  endtask

  task automatic test_basic_frames();
    byte_q_t pl;
    send_packet(8'h00, pl, 16'h0000);     // empty payload
    pl.push_back(8'h00);
    pl.push_back(8'hFF);
    send_packet(8'hFF, pl, 16'h0000);
    send_byte(head_val);                  // short frame, head then tail
    send_byte(tail_val);
    send_byte(head_val);                  // short frame, four bytes
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(tail_val);
    pl.delete();
    pl.push_back(8'h34);
    send_packet(8'h12, pl, 16'h0100);     // bad CRC
    wait_quiet();
  endtask

  task automatic test_head_change_mid_frame();
    byte_q_t     pl;
    logic [15:0] crc;
    crc = crc_fold(crc_fold(crc_fold(CrcInit, head_val), 8'h11), 8'h22);
    send_byte(head_val);
    send_byte(8'h11);
    send_byte(8'h22);
    wait_quiet();
    set_markers(8'h3A, tail_val);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    send_byte(tail_val);
    wait_quiet();
    set_markers(HeadReset, TailReset);
    pl.push_back(8'h22);
    send_packet(8'h11, pl, 16'h0000);
    wait_quiet();
  endtask

  task automatic test_max_payload();
    send_packet(8'hA5, rand_payload(MaxPayloadBytes), 16'h0000);
    wait_quiet();
  endtask

  task automatic test_store_full();
    byte_q_t pl;
    send_packet(8'h3C, rand_payload(MaxPayloadBytes + 1), 16'h0000);  // tail gets dropped
    send_packet(8'h07, pl, 16'h0000);
    wait_quiet();
  endtask

  task automatic test_marker_extremes();
    set_markers(8'h00, 8'hFF);
    repeat (4) send_random_frame();
    wait_quiet();
    set_markers(8'hFF, 8'h00);
    repeat (4) send_random_frame();
    wait_quiet();
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_taken + n_items;
    while (items_taken < stop_at) begin
      rx_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : 25;
      res_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
      send_random_frame();
    end
    wait_quiet();
  endtask

  task automatic test_random_traffic();
    run_random_phase(30);
    repeat (2) begin
      set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random_phase(30);
    end
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_packet(8'h5A, rand_payload(MaxPayloadBytes), 16'h0000);
    run_random_phase(25);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = CfgHead;
    cfg.data      = 8'h00;
    rxb.valid     = 1'b0;
    rxb.rx_byte   = 8'h00;
    res.ready     = 1'b0;
    stall_left    = 0;
    mismatches    = 0;
    items_taken   = 0;
    idle_en       = 1'b1;
    rx_gap_pct    = 25;
    res_stall_pct = 20;
    head_val      = HeadReset;
    tail_val      = TailReset;
    rx_len        = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_frames();
    test_head_change_mid_frame();
    test_max_payload();
    test_store_full();
    test_marker_extremes();
    test_random_traffic();
    test_full_rate();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cfpr_pkg.sv
rtl/cfpr_ifs.sv
rtl/crc16_framed_packet_receiver.sv
sim/tb_crc16_framed_packet_receiver.sv
